FILE: rtl/core/prx_pkg.sv
// ============================================================================
// prx_pkg - shared types and constants of the packet receiver
// Codes for modes, statuses, replies and receive phases, and default sizes.
// ============================================================================
`default_nettype none

package prx_pkg;

    // Default sizes and register reset values
    localparam int PAYLOAD_BYTES_DEF = 120;
    localparam int SEQ_MODULUS_DEF   = 8;
    localparam logic [7:0] MAX_ERRORS_RST = 8'd20;

    // Field widths
    localparam int MODE_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 7;
    localparam int REPLY_W  = 2;

    // Start-of-packet byte after masking bit 7
    localparam logic [6:0] SOH_CODE  = 7'h01;
    localparam logic [7:0] ERR_SAT   = 8'hff;

    typedef enum logic [MODE_W-1:0] {
        MODE_BYTE    = 2'd0,
        MODE_TIMEOUT = 2'd1,
        MODE_OPEN    = 2'd2
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DATA     = 3'd0,
        ST_ACCEPTED = 3'd1,
        ST_BAD_CHK  = 3'd2,
        ST_BAD_SEQ  = 3'd3,
        ST_TIMEOUT  = 3'd4,
        ST_FAILED   = 3'd5
    } t_status;

    typedef enum logic [REPLY_W-1:0] {
        RPL_NONE = 2'd0,
        RPL_ACK  = 2'd1,
        RPL_NAK  = 2'd2
    } t_reply;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_PAYLOAD = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        HDR_LENGTH = 2'd0,
        HDR_SEQ    = 2'd1,
        HDR_CHECK  = 2'd2
    } t_hdr_pos;

endpackage

`default_nettype wire

FILE: rtl/core/prx_in_if.sv
// ============================================================================
// prx_in_if - input item channel of the packet receiver
// Carries one line event: mode and line byte, with valid/ready handshake.
// ============================================================================
`default_nettype none

interface prx_in_if;
    logic                            valid;
    logic                            ready;
    logic [prx_pkg::MODE_W-1:0]      mode;
    logic [prx_pkg::BYTE_W-1:0]      line_byte;

    modport source (output valid, output mode, output line_byte, input ready);
    modport sink   (input valid, input mode, input line_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/prx_out_if.sv
// ============================================================================
// prx_out_if - result item channel of the packet receiver
// Carries status, payload byte, header fields and reply with valid/ready.
// ============================================================================
`default_nettype none

interface prx_out_if;
    logic                            valid;
    logic                            ready;
    logic [prx_pkg::STATUS_W-1:0]    status;
    logic [prx_pkg::BYTE_W-1:0]      data_byte;
    logic [prx_pkg::INDEX_W-1:0]     byte_index;
    logic [prx_pkg::BYTE_W-1:0]      packet_length;
    logic [prx_pkg::BYTE_W-1:0]      packet_seq;
    logic [prx_pkg::REPLY_W-1:0]     reply;
    logic                            limit_reached;

    modport source (output valid, output status, output data_byte, output byte_index,
                    output packet_length, output packet_seq, output reply,
                    output limit_reached, input ready);
    modport sink   (input valid, input status, input data_byte, input byte_index,
                    input packet_length, input packet_seq, input reply,
                    input limit_reached, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/prx_cfg_if.sv
// ============================================================================
// prx_cfg_if - configuration write channel of the packet receiver
// Carries the error limit register write data with valid/ready.
// ============================================================================
`default_nettype none

interface prx_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [prx_pkg::BYTE_W-1:0]      max_errors;

    modport source (output valid, output max_errors, input ready);
    modport sink   (input valid, input max_errors, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/packet_receiver_xor_ack.sv
// ============================================================================
// packet_receiver_xor_ack - receive side of a fixed-size packet link
// Hunts for the start byte, takes length/sequence/check header bytes, then
// the payload bytes with an XOR check, and reports the verdict with ACK/NAK.
// ============================================================================
//
//  channel   dir  handshake          payload
//  --------  ---  -----------------  -----------------------------------------
//  i_in_ch   in   valid/ready        mode, line_byte
//  i_cfg_ch  in   valid/ready        max_errors (always ready)
//  o_out_ch  out  valid/ready        status, data_byte, byte_index,
//                                    packet_length, packet_seq, reply,
//                                    limit_reached
//
//  One item per cycle: each item is decoded and applied to the link state in
//  the cycle it is taken, and its result lands in the output register.
//  Input ready is high while the output register is empty or being drained,
//  so a stalled result holds the input only until the sink takes it.
//  Synchronous active-low reset returns to hunting with counters cleared and
//  the error limit at 20.
// ============================================================================
`default_nettype none

module packet_receiver_xor_ack #(
    parameter int PAYLOAD_BYTES = prx_pkg::PAYLOAD_BYTES_DEF,
    parameter int SEQ_MODULUS   = prx_pkg::SEQ_MODULUS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    prx_in_if.sink     i_in_ch,
    prx_cfg_if.sink    i_cfg_ch,
    prx_out_if.source  o_out_ch
);

    localparam int SEQ_W = (SEQ_MODULUS > 1) ? $clog2(SEQ_MODULUS) : 1;
    localparam logic [SEQ_W-1:0] SEQ_LAST = SEQ_W'(SEQ_MODULUS - 1);
    localparam logic [prx_pkg::INDEX_W:0] PAY_LEN = (prx_pkg::INDEX_W + 1)'(PAYLOAD_BYTES);

    // Link state
    prx_pkg::t_phase                 r_phase,    n_phase;
    prx_pkg::t_hdr_pos               r_hdr_pos,  n_hdr_pos;
    logic [prx_pkg::INDEX_W-1:0]     r_pay_pos,  n_pay_pos;
    logic [prx_pkg::BYTE_W-1:0]      r_length,   n_length;
    logic [prx_pkg::BYTE_W-1:0]      r_seq,      n_seq;
    logic [prx_pkg::BYTE_W-1:0]      r_check,    n_check;
    logic [SEQ_W-1:0]                r_exp_seq,  n_exp_seq;
    logic [prx_pkg::BYTE_W-1:0]      r_err_cnt,  n_err_cnt;
    logic [prx_pkg::BYTE_W-1:0]      r_max_err;

    // Output register
    logic                            r_out_valid;
    prx_pkg::t_status                r_status,   n_status;
    logic [prx_pkg::BYTE_W-1:0]      r_data,     n_data;
    logic [prx_pkg::INDEX_W-1:0]     r_index,    n_index;
    logic [prx_pkg::BYTE_W-1:0]      r_out_len,  n_out_len;
    logic [prx_pkg::BYTE_W-1:0]      r_out_seq,  n_out_seq;
    prx_pkg::t_reply                 r_reply,    n_reply;
    logic                            r_limit,    n_limit;

    logic                            emit;
    logic                            in_fire;
    logic                            link_failed;
    logic [prx_pkg::INDEX_W:0]       pos_inc;
    logic [prx_pkg::BYTE_W-1:0]      chk_new;
    logic [prx_pkg::BYTE_W-1:0]      err_inc;
    prx_pkg::t_mode                  mode;

    // Handshakes
    assign i_in_ch.ready  = !r_out_valid || o_out_ch.ready;
    assign i_cfg_ch.ready = 1'b1;
    assign in_fire        = i_in_ch.valid && i_in_ch.ready;

    assign mode        = prx_pkg::t_mode'(i_in_ch.mode);
    assign link_failed = (r_err_cnt >= r_max_err);
    assign pos_inc     = {1'b0, r_pay_pos} + (prx_pkg::INDEX_W + 1)'(1);
    assign chk_new     = r_check ^ i_in_ch.line_byte;
    assign err_inc     = (r_err_cnt == prx_pkg::ERR_SAT) ? r_err_cnt
                                                         : r_err_cnt + 8'd1;

    // Decode one item against the link state
    always_comb begin
        n_phase   = r_phase;
        n_hdr_pos = r_hdr_pos;
        n_pay_pos = r_pay_pos;
        n_length  = r_length;
        n_seq     = r_seq;
        n_check   = r_check;
        n_exp_seq = r_exp_seq;
        n_err_cnt = r_err_cnt;
        emit      = 1'b0;
        n_status  = prx_pkg::ST_DATA;
        n_data    = '0;
        n_index   = '0;
        n_out_len = '0;
        n_out_seq = '0;
        n_reply   = prx_pkg::RPL_NONE;
        n_limit   = 1'b0;

        case (mode)
            prx_pkg::MODE_OPEN: begin
                n_err_cnt = '0;
                n_exp_seq = '0;
                n_phase   = prx_pkg::PH_HUNT;
                n_hdr_pos = prx_pkg::HDR_LENGTH;
                n_pay_pos = '0;
                n_check   = '0;
            end
            prx_pkg::MODE_TIMEOUT: begin
                emit = 1'b1;
                if (link_failed) begin
                    n_status = prx_pkg::ST_FAILED;
                end else begin
                    n_status  = prx_pkg::ST_TIMEOUT;
                    n_phase   = prx_pkg::PH_HUNT;
                    n_hdr_pos = prx_pkg::HDR_LENGTH;
                    n_pay_pos = '0;
                    n_check   = '0;
                end
            end
            prx_pkg::MODE_BYTE: begin
                if (link_failed) begin
                    emit     = 1'b1;
                    n_status = prx_pkg::ST_FAILED;
                end else begin
                    case (r_phase)
                        prx_pkg::PH_HUNT: begin
                            if (i_in_ch.line_byte[6:0] == prx_pkg::SOH_CODE) begin
                                n_phase   = prx_pkg::PH_HEADER;
                                n_hdr_pos = prx_pkg::HDR_LENGTH;
                            end
                        end
                        prx_pkg::PH_HEADER: begin
                            case (r_hdr_pos)
                                prx_pkg::HDR_LENGTH: begin
                                    n_length  = i_in_ch.line_byte;
                                    n_hdr_pos = prx_pkg::HDR_SEQ;
                                end
                                prx_pkg::HDR_SEQ: begin
                                    n_seq     = i_in_ch.line_byte;
                                    n_hdr_pos = prx_pkg::HDR_CHECK;
                                end
                                default: begin
                                    n_check   = i_in_ch.line_byte;
                                    n_hdr_pos = prx_pkg::HDR_LENGTH;
                                    n_pay_pos = '0;
                                    n_phase   = prx_pkg::PH_PAYLOAD;
                                end
                            endcase
                        end
                        prx_pkg::PH_PAYLOAD: begin
                            emit    = 1'b1;
                            n_data  = i_in_ch.line_byte;
                            n_index = r_pay_pos;
                            if (pos_inc < PAY_LEN) begin
                                // Mid-packet byte: advance position, fold check
                                n_check   = chk_new;
                                n_pay_pos = pos_inc[prx_pkg::INDEX_W-1:0];
                                n_status  = prx_pkg::ST_DATA;
                            end else begin
                                // Last byte: give the verdict and restart
                                n_out_len = r_length;
                                n_out_seq = r_seq;
                                if (chk_new != '0) begin
                                    n_status = prx_pkg::ST_BAD_CHK;
                                    n_reply  = prx_pkg::RPL_NAK;
                                end else if (r_seq != prx_pkg::BYTE_W'(r_exp_seq)) begin
                                    n_status = prx_pkg::ST_BAD_SEQ;
                                    n_reply  = prx_pkg::RPL_ACK;
                                end else begin
                                    n_status  = prx_pkg::ST_ACCEPTED;
                                    n_reply   = prx_pkg::RPL_ACK;
                                    n_exp_seq = (r_exp_seq == SEQ_LAST) ? '0
                                                                        : r_exp_seq + 1'b1;
                                end
                                if (n_status != prx_pkg::ST_ACCEPTED) begin
                                    n_err_cnt = err_inc;
                                    n_limit   = (err_inc >= r_max_err);
                                end
                                n_phase   = prx_pkg::PH_HUNT;
                                n_hdr_pos = prx_pkg::HDR_LENGTH;
                                n_pay_pos = '0;
                                n_check   = '0;
                            end
                        end
                        default: begin
                            n_phase   = prx_pkg::PH_HUNT;
                            n_hdr_pos = prx_pkg::HDR_LENGTH;
                            n_pay_pos = '0;
                            n_check   = '0;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    // Update link state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= prx_pkg::PH_HUNT;
            r_hdr_pos <= prx_pkg::HDR_LENGTH;
            r_pay_pos <= '0;
            r_check   <= '0;
            r_exp_seq <= '0;
            r_err_cnt <= '0;
            r_length  <= '0;
            r_seq     <= '0;
        end else if (in_fire) begin
            r_phase   <= n_phase;
            r_hdr_pos <= n_hdr_pos;
            r_pay_pos <= n_pay_pos;
            r_check   <= n_check;
            r_exp_seq <= n_exp_seq;
            r_err_cnt <= n_err_cnt;
            r_length  <= n_length;
            r_seq     <= n_seq;
        end
    end

    // Hold the error limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_err <= prx_pkg::MAX_ERRORS_RST;
        end else if (i_cfg_ch.valid) begin
            r_max_err <= i_cfg_ch.max_errors;
        end
    end

    // Output valid: set on an emitting item, drop when the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the result payload
    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_status  <= n_status;
            r_data    <= n_data;
            r_index   <= n_index;
            r_out_len <= n_out_len;
            r_out_seq <= n_out_seq;
            r_reply   <= n_reply;
            r_limit   <= n_limit;
        end
    end

    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.status        = r_status;
    assign o_out_ch.data_byte     = r_data;
    assign o_out_ch.byte_index    = r_index;
    assign o_out_ch.packet_length = r_out_len;
    assign o_out_ch.packet_seq    = r_out_seq;
    assign o_out_ch.reply         = r_reply;
    assign o_out_ch.limit_reached = r_limit;

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ============================================================================
// tb - self-checking testbench of packet_receiver_xor_ack
// Walks a short table of directed line events, then random packets, noise,
// timeouts and session opens under several error limits and idling patterns.
// Every result item is checked field by field against an in-bench predictor,
// or against the literal result of its row in the directed table.
`default_nettype none

module tb;

    localparam int PAYLOAD        = prx_pkg::PAYLOAD_BYTES_DEF;
    localparam int SEQ_MOD        = prx_pkg::SEQ_MODULUS_DEF;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES    = 200;
    localparam int IDLE_LIMIT     = 3000;
    localparam int PHASE_ITEMS    = 130;

    typedef struct packed {
        prx_pkg::t_status status;
        logic [7:0]       data;
        logic [6:0]       idx;
        logic [7:0]       len;
        logic [7:0]       seq;
        prx_pkg::t_reply  reply;
        logic             lim;
    } t_rx_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [1:0] md;
        logic [7:0] lb;
        bit         lit;
        bit         has;
        t_rx_res    res;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    prx_in_if  in_ch();
    prx_cfg_if cfg_ch();
    prx_out_if out_ch();

    packet_receiver_xor_ack i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .i_cfg_ch (cfg_ch),
        .o_out_ch (out_ch)
    );

    // Predicted link state
    logic [7:0]        lim_max_err;
    prx_pkg::t_phase   lnk_phase;
    prx_pkg::t_hdr_pos lnk_hdr_pos;
    logic [6:0]        lnk_pos;
    logic [7:0]        lnk_len;
    logic [7:0]        lnk_seq;
    logic [7:0]        lnk_chk;
    logic [2:0]        lnk_exp_seq;
    logic [7:0]        lnk_err_cnt;

    t_rx_res exp_rx_q[$];
    t_dir_row dir_tab[$];

    int fail_cnt = 0;
    int items_in = 0;
    int results_seen = 0;
    int status_cnt[6] = '{default: 0};
    int in_gap_pct = 0;
    int out_stall_pct = 0;
    int hold_reqs = 0;
    int hold_done = 0;
    int hold_left = 0;
    int idle_cyc = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Drop back to hunting, forget the packet in progress
    function automatic void lnk_restart();
        lnk_phase   = prx_pkg::PH_HUNT;
        lnk_hdr_pos = prx_pkg::HDR_LENGTH;
        lnk_pos     = '0;
        lnk_chk     = '0;
    endfunction

    // Apply one accepted line event to the predicted link, return its result
    function automatic void rx_predict(input logic [1:0] md, input logic [7:0] lb,
                                       output bit has, output t_rx_res r);
        r   = '0;
        has = 1'b0;
        if (md == prx_pkg::MODE_OPEN) begin
            lnk_err_cnt = '0;
            lnk_exp_seq = '0;
            lnk_restart();
            return;
        end
        if (md == MODE_UNUSED)
            return;
        has = 1'b1;
        if (lnk_err_cnt >= lim_max_err) begin
            r.status = prx_pkg::ST_FAILED;
            return;
        end
        if (md == prx_pkg::MODE_TIMEOUT) begin
            lnk_restart();
            r.status = prx_pkg::ST_TIMEOUT;
            return;
        end
        has = 1'b0;
        case (lnk_phase)
            prx_pkg::PH_HUNT: begin
                if (lb[6:0] == prx_pkg::SOH_CODE) begin
                    lnk_phase   = prx_pkg::PH_HEADER;
                    lnk_hdr_pos = prx_pkg::HDR_LENGTH;
                end
            end
            prx_pkg::PH_HEADER: begin
                case (lnk_hdr_pos)
                    prx_pkg::HDR_LENGTH: begin
                        lnk_len     = lb;
                        lnk_hdr_pos = prx_pkg::HDR_SEQ;
                    end
                    prx_pkg::HDR_SEQ: begin
                        lnk_seq     = lb;
                        lnk_hdr_pos = prx_pkg::HDR_CHECK;
                    end
                    default: begin
                        lnk_chk     = lb;
                        lnk_hdr_pos = prx_pkg::HDR_LENGTH;
                        lnk_pos     = '0;
                        lnk_phase   = prx_pkg::PH_PAYLOAD;
                    end
                endcase
            end
            default: begin
                has     = 1'b1;
                lnk_chk = lnk_chk ^ lb;
                r.data  = lb;
                r.idx   = lnk_pos;
                if (int'(lnk_pos) + 1 < PAYLOAD) begin
                    lnk_pos  = lnk_pos + 7'd1;
                    r.status = prx_pkg::ST_DATA;
                    return;
                end
                // Last byte: give the verdict
                if (lnk_chk != 8'd0) begin
                    r.status = prx_pkg::ST_BAD_CHK;
                    r.reply  = prx_pkg::RPL_NAK;
                end else if (lnk_seq != {5'd0, lnk_exp_seq}) begin
                    r.status = prx_pkg::ST_BAD_SEQ;
                    r.reply  = prx_pkg::RPL_ACK;
                end else begin
                    r.status    = prx_pkg::ST_ACCEPTED;
                    r.reply     = prx_pkg::RPL_ACK;
                    lnk_exp_seq = 3'((int'(lnk_exp_seq) + 1) % SEQ_MOD);
                end
                if (r.status != prx_pkg::ST_ACCEPTED) begin
                    if (lnk_err_cnt != prx_pkg::ERR_SAT)
                        lnk_err_cnt = lnk_err_cnt + 8'd1;
                    r.lim = (lnk_err_cnt >= lim_max_err);
                end
                r.len = lnk_len;
                r.seq = lnk_seq;
                lnk_restart();
            end
        endcase
    endfunction

    function automatic t_dir_row mk_row(t_row_kind k, logic [1:0] md, logic [7:0] lb,
                                        bit lit, bit has, prx_pkg::t_status st,
                                        logic [7:0] d, logic [6:0] ix);
        t_dir_row w;
        w.kind       = k;
        w.md         = md;
        w.lb         = lb;
        w.lit        = lit;
        w.has        = has;
        w.res        = '0;
        w.res.status = st;
        w.res.data   = d;
        w.res.idx    = ix;
        return w;
    endfunction

    // Offer one item, hold it until taken, then queue what it should produce
    task automatic send_item(input logic [1:0] md, input logic [7:0] lb,
                             input bit lit, input bit lit_has, input t_rx_res lit_res);
        bit      has;
        t_rx_res r;
        while (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.mode      <= md;
        in_ch.line_byte <= lb;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        rx_predict(md, lb, has, r);
        if (lit) begin
            has = lit_has;
            r   = lit_res;
        end
        if (has)
            exp_rx_q.push_back(r);
        if (md != MODE_UNUSED)
            items_in++;
    endtask

    task automatic send(input logic [1:0] md, input logic [7:0] lb);
        send_item(md, lb, 1'b0, 1'b0, '0);
    endtask

    // Hold until every expected result is out, then let the pipe settle
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (exp_rx_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_err(input logic [7:0] v);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.max_errors <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        lim_max_err = v;
    endtask

    // One packet with random content, often well formed, sometimes cut short
    task automatic send_packet();
        logic [7:0] pkt[PAYLOAD + 4];
        logic [7:0] xsum;
        int         cut;
        int         k;
        xsum = '0;
        for (k = 0; k < PAYLOAD; k++) begin
            pkt[k + 4] = 8'($urandom_range(255));
            xsum       = xsum ^ pkt[k + 4];
        end
        pkt[0] = ($urandom_range(1) == 1) ? 8'h81 : 8'h01;
        pkt[1] = 8'($urandom_range(255));
        pkt[2] = ($urandom_range(99) < 70) ? {5'd0, lnk_exp_seq} : 8'($urandom_range(255));
        pkt[3] = ($urandom_range(99) < 70) ? xsum : 8'($urandom_range(255));
        cut    = ($urandom_range(99) < 6) ? $urandom_range(PAYLOAD + 3) : -1;
        for (k = 0; k < PAYLOAD + 4; k++) begin
            if (k == cut) begin
                send(($urandom_range(1) == 1) ? prx_pkg::MODE_TIMEOUT : prx_pkg::MODE_OPEN,
                     8'($urandom_range(255)));
                return;
            end
            send(prx_pkg::MODE_BYTE, pkt[k]);
        end
    endtask

    // Random traffic under one error limit and one idling pattern
    task automatic run_phase(input logic [7:0] max_err, input int gap_pct,
                             input int stall_pct, input bit hold);
        int stop_at;
        int pick;
        wait_drained();
        write_max_err(max_err);
        in_gap_pct    = gap_pct;
        out_stall_pct = stall_pct;
        if (hold)
            hold_reqs++;
        stop_at       = items_in + PHASE_ITEMS;
        while (items_in < stop_at) begin
            pick = $urandom_range(99);
            if (lnk_err_cnt >= lim_max_err && $urandom_range(1) == 1)
                send(prx_pkg::MODE_OPEN, 8'($urandom_range(255)));
            else if (pick < 80)
                send_packet();
            else if (pick < 88)
                send(prx_pkg::MODE_BYTE, 8'($urandom_range(255)));
            else if (pick < 93)
                send(prx_pkg::MODE_TIMEOUT, 8'($urandom_range(255)));
            else if (pick < 97)
                send(prx_pkg::MODE_OPEN, 8'($urandom_range(255)));
            else
                send(MODE_UNUSED, 8'($urandom_range(255)));
        end
    endtask

    // Take results, check them, and pick the next ready
    always @(posedge i_clk) begin
        t_rx_res act;
        t_rx_res e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            act.status = prx_pkg::t_status'(out_ch.status);
            act.data   = out_ch.data_byte;
            act.idx    = out_ch.byte_index;
            act.len    = out_ch.packet_length;
            act.seq    = out_ch.packet_seq;
            act.reply  = prx_pkg::t_reply'(out_ch.reply);
            act.lim    = out_ch.limit_reached;
            if (exp_rx_q.size() == 0) begin
                $display("%0t: result exp none got status %0d", $time, act.status);
                fail_cnt++;
            end else begin
                e = exp_rx_q.pop_front();
                results_seen++;
                if (int'(e.status) < 6)
                    status_cnt[e.status]++;
                if (act.status !== e.status)
                    $display("%0t: status exp %0d got %0d", $time, e.status, act.status);
                if (act.data !== e.data)
                    $display("%0t: data_byte exp %h got %h", $time, e.data, act.data);
                if (act.idx !== e.idx)
                    $display("%0t: byte_index exp %0d got %0d", $time, e.idx, act.idx);
                if (act.len !== e.len)
                    $display("%0t: packet_length exp %h got %h", $time, e.len, act.len);
                if (act.seq !== e.seq)
                    $display("%0t: packet_seq exp %h got %h", $time, e.seq, act.seq);
                if (act.reply !== e.reply)
                    $display("%0t: reply exp %0d got %0d", $time, e.reply, act.reply);
                if (act.lim !== e.lim)
                    $display("%0t: limit_reached exp %0d got %0d", $time, e.lim, act.lim);
                if (act !== e)
                    fail_cnt++;
            end
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_done != hold_reqs) begin
            out_ch.ready <= 1'b0;
            hold_left = HOLD_CYCLES;
            hold_done = hold_reqs;
        end else begin
            out_ch.ready <= !(out_stall_pct > 0 && $urandom_range(99) < out_stall_pct);
        end
    end

    // Give up when nothing moves for too long
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cyc <= 0;
        end else if (idle_cyc >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cyc);
            $display("tb failed");
            $finish;
        end else begin
            idle_cyc <= idle_cyc + 1;
        end
    end

    initial begin
        int lost;
        in_ch.valid       <= 1'b0;
        in_ch.mode        <= prx_pkg::MODE_BYTE;
        in_ch.line_byte   <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.max_errors <= prx_pkg::MAX_ERRORS_RST;
        i_rst_n           <= 1'b0;
        lim_max_err = prx_pkg::MAX_ERRORS_RST;
        lnk_restart();
        lnk_len     = '0;
        lnk_seq     = '0;
        lnk_exp_seq = '0;
        lnk_err_cnt = '0;

        // Directed events: hunting, every mode, a short packet start, failed link
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h00, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_TIMEOUT, 8'hff, 1, 1,
                                 prx_pkg::ST_TIMEOUT, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, MODE_UNUSED, 8'hff, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_OPEN, 8'h00, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h81, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'hff, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h00, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'hff, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'hff, 1, 1,
                                 prx_pkg::ST_DATA, 8'hff, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h00, 1, 1,
                                 prx_pkg::ST_DATA, 8'h00, 7'd1));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_TIMEOUT, 8'h00, 1, 1,
                                 prx_pkg::ST_TIMEOUT, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h01, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h7e, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h07, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h5a, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'ha5, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_OPEN, 8'hff, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'ha5, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        // Zero error limit: the link counts as failed at once
        dir_tab.push_back(mk_row(ROW_CFG, prx_pkg::MODE_BYTE, 8'h00, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h01, 1, 1,
                                 prx_pkg::ST_FAILED, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_TIMEOUT, 8'h00, 1, 1,
                                 prx_pkg::ST_FAILED, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, MODE_UNUSED, 8'h00, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_OPEN, 8'h00, 1, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h80, 1, 1,
                                 prx_pkg::ST_FAILED, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_CFG, prx_pkg::MODE_BYTE, 8'hff, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));
        dir_tab.push_back(mk_row(ROW_ITEM, prx_pkg::MODE_BYTE, 8'h02, 0, 0,
                                 prx_pkg::ST_DATA, 8'h00, 7'd0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                wait_drained();
                write_max_err(dir_tab[k].lb);
            end else begin
                send_item(dir_tab[k].md, dir_tab[k].lb, dir_tab[k].lit,
                          dir_tab[k].has, dir_tab[k].res);
            end
        end

        // Random traffic: limits and idling patterns per phase
        run_phase(8'd2,   0,  0,  1'b1);
        run_phase(8'd1,   47, 0,  1'b0);
        run_phase(8'd255, 0,  47, 1'b0);
        run_phase(8'd20,  11, 11, 1'b0);
        run_phase(8'd3,   0,  0,  1'b0);

        wait_drained();
        lost = exp_rx_q.size();
        if (lost != 0)
            $display("%0t: results exp %0d more got none", $time, lost);
        $display("run: %0d line events taken, %0d result items checked, %0d mismatches",
                 items_in, results_seen, fail_cnt);
        $display("verdicts: %0d ok, %0d bad check, %0d bad seq, %0d timeout, %0d failed",
                 status_cnt[prx_pkg::ST_ACCEPTED], status_cnt[prx_pkg::ST_BAD_CHK],
                 status_cnt[prx_pkg::ST_BAD_SEQ], status_cnt[prx_pkg::ST_TIMEOUT],
                 status_cnt[prx_pkg::ST_FAILED]);
        if (fail_cnt == 0 && lost == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

`default_nettype wire
